FILE: src/savgol_baseline_remover_defines.svh
// Assertion macros for the baseline remover
`ifndef SAVGOL_BASELINE_REMOVER_DEFINES_SVH
`define SAVGOL_BASELINE_REMOVER_DEFINES_SVH
// implication checked every clock outside reset
`define SBR_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("label failed");
// implication checked on the following clock
`define SBR_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("label failed");
`endif

FILE: src/sbr_pkg.sv
// Package: widths, opcodes and state codes for the baseline remover
`timescale 1ns / 1ps
`default_nettype none
package sbr_pkg;
   localparam int MAX_HALF_WIDTH = 15;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 20;
   localparam int COEF_BITS      = 24;
   localparam int ADDR_BITS      = 9;
   localparam int HW_BITS        = 4;
   localparam bit OP_COEF        = 1'b0;
   localparam bit OP_SAMPLE      = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PLAN  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_MAC   = 6'b001000,
      ST_ROUND = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;
endpackage
`default_nettype wire

FILE: src/sbr_stream_if.sv
// Valid/ready channel interface carrying request and response beats
`timescale 1ns / 1ps
`default_nettype none
interface sbr_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    operation;
   logic [sbr_pkg::ADDR_BITS-1:0]           coef_address;
   logic signed [sbr_pkg::COEF_BITS-1:0]    coef_value;
   logic signed [sbr_pkg::SAMPLE_BITS-1:0]  sample;
   logic                                    last_sample;
   modport source (output valid, operation, coef_address, coef_value, sample, last_sample,
                   input ready);
   modport sink   (input valid, operation, coef_address, coef_value, sample, last_sample,
                   output ready);
endinterface

interface sbr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sbr_pkg::SAMPLE_BITS:0]   corrected;
   logic signed [sbr_pkg::SAMPLE_BITS-1:0] baseline;
   logic                                   last_result;
   modport source (output valid, corrected, baseline, last_result, input ready);
   modport sink   (input valid, corrected, baseline, last_result, output ready);
endinterface
`default_nettype wire

FILE: src/sbr_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
`default_nettype none
module sbr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: src/savgol_baseline_remover.sv
// Top level: Savitzky-Golay baseline remover with one shared multiply-accumulate
//  channel | dir | beat
//  req     | in  | coefficient write or one sample
//  rsp     | out | corrected sample, baseline, last flag
//  csr     | in  | half width
// A coefficient write, or a sample that completes no result, leaves the block idle.
// A sample with results is worked through plan, a read and a multiply per tap, round
// and out for each fitted result, or plan, round and out for each pass-through result;
// window = 2*half_width+1, up to 31 taps; up to window results at a record's end.
// Reset (synchronous) clears history to zero, the count and the half width; coefficients are not.
// req is held off while a sample is worked; a waiting rsp beat holds the next result.
`timescale 1ns / 1ps
`default_nettype none
`include "savgol_baseline_remover_defines.svh"
module savgol_baseline_remover #(
   parameter int COEF_FRAC_BITS = sbr_pkg::COEF_FRAC_BITS
) (
   input wire logic clock,
   input wire logic reset,
   sbr_req_if.sink   req,
   sbr_rsp_if.source rsp,
   input wire logic                          csr_write_enable,
   input wire logic [sbr_pkg::HW_BITS-1:0]   csr_write_data
);
   localparam int SAMPLE_BITS = sbr_pkg::SAMPLE_BITS;
   localparam int CB   = sbr_pkg::COEF_BITS;
   localparam int PB   = CB + SAMPLE_BITS;
   localparam int AB   = PB + 5;

   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_CENTRE = 2'd1;
   localparam logic [1:0] MODE_HEAD   = 2'd2;
   localparam logic [1:0] MODE_TAIL   = 2'd3;

   logic [sbr_pkg::HW_BITS-1:0] hw_ff;
   sbr_pkg::state_type          state_ff, state_in;
   logic [SAMPLE_BITS-1:0]      hist_ff [32];
   logic [5:0]                  seen_ff;
   logic [4:0]                  e_ff;      // index of newest sample
   logic                        last_ff;
   logic [4:0]                  left_ff;   // results still to emit
   logic [1:0]                  mode_ff;
   logic [4:0]                  idx_ff;    // head/pass index or tail i
   logic [4:0]                  tap_ff;
   logic [4:0]                  set_ff;
   logic [4:0]                  hstart_ff;
   logic                        hdir_ff;   // 1 = backwards
   logic [4:0]                  pos_ff;
   logic signed [AB-1:0]        acc_ff;
   logic signed [PB-1:0]        prod_ff;
   logic                        pv_ff;
   logic signed [SAMPLE_BITS-1:0] hs_ff;
   logic signed [SAMPLE_BITS-1:0] base_ff;
   logic                        zero_ff;
   logic                        plast_ff;  // last flag of the result being built
   logic                        rlast_ff;
   logic                        rvalid_ff;
   logic signed [SAMPLE_BITS:0] rcorr_ff;
   logic signed [SAMPLE_BITS-1:0] rbase_ff;
   logic [4:0]                  taps_ff;

   logic [CB-1:0] coef_rd;
   logic [sbr_pkg::ADDR_BITS-1:0] rd_addr;
   logic [3:0] hw;
   assign hw = (32'(hw_ff) > sbr_pkg::MAX_HALF_WIDTH)
               ? 4'(sbr_pkg::MAX_HALF_WIDTH) : hw_ff;

   wire acc_req = req.valid && req.ready;
   assign req.ready = (state_ff == sbr_pkg::ST_IDLE);
   assign rd_addr = {set_ff[3:0], tap_ff};

   sbr_ram #(.WIDTH(CB), .DEPTH(512)) u_coef (
      .clock  (clock),
      .wr_en  (acc_req && req.operation == sbr_pkg::OP_COEF),
      .wr_addr(req.coef_address),
      .wr_data(req.coef_value),
      .rd_addr(rd_addr),
      .rd_data(coef_rd)
   );

   logic [4:0] h_idx;
   assign h_idx = hdir_ff ? 5'(hstart_ff - tap_ff) : 5'(hstart_ff + tap_ff);

   logic signed [AB-1:0] rnd;
   logic signed [AB-1:0] rsh;
   logic signed [SAMPLE_BITS-1:0] sat;
   always_comb begin
      rnd = acc_ff + (AB'(1) <<< (COEF_FRAC_BITS - 1));
      rsh = rnd >>> COEF_FRAC_BITS;
      if (rsh > AB'((1 <<< (SAMPLE_BITS - 1)) - 1))
         sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      else if (rsh < -AB'(1 <<< (SAMPLE_BITS - 1)))
         sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else
         sat = rsh[SAMPLE_BITS-1:0];
   end

   wire rsp_free = !rvalid_ff || rsp.ready;
   wire out_fire = (state_ff == sbr_pkg::ST_OUT) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sbr_pkg::ST_IDLE;
         hw_ff     <= '0;
         seen_ff   <= '0;
         rvalid_ff <= 1'b0;
         pv_ff     <= 1'b0;
         for (int i = 0; i < 32; i++) hist_ff[i] <= '0;
      end else begin
         if (csr_write_enable) hw_ff <= csr_write_data;
         if (out_fire) rvalid_ff <= 1'b1;
         else if (rsp.ready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            sbr_pkg::ST_IDLE: begin
               if (acc_req && req.operation == sbr_pkg::OP_SAMPLE) begin
                  hist_ff[seen_ff[4:0]] <= req.sample;
                  e_ff    <= seen_ff[4:0];
                  last_ff <= req.last_sample;
                  taps_ff <= 5'({hw, 1'b0});
                  state_ff <= sbr_pkg::ST_PLAN;
                  if (hw == 0) begin
                     seen_ff <= '0;
                     mode_ff <= MODE_PASS; left_ff <= 5'd1; idx_ff <= seen_ff[4:0];
                  end else if (req.last_sample) begin
                     seen_ff <= '0;
                     if (7'(seen_ff) + 7'd1 <= 7'({hw, 1'b1})) begin
                        mode_ff <= MODE_PASS; idx_ff <= '0;
                        left_ff <= 5'(seen_ff + 6'd1);
                     end else begin
                        mode_ff <= MODE_CENTRE; idx_ff <= 5'(hw);
                        left_ff <= 5'(5'(hw) + 5'd1);
                     end
                  end else begin
                     seen_ff <= (seen_ff == 6'd63) ? 6'd32 : 6'(seen_ff + 6'd1);
                     if (7'(seen_ff) + 7'd1 == 7'({hw, 1'b1})) begin
                        mode_ff <= MODE_HEAD; idx_ff <= '0;
                        left_ff <= 5'(5'(hw) + 5'd1);
                     end else if (7'(seen_ff) + 7'd1 > 7'({hw, 1'b1})) begin
                        mode_ff <= MODE_CENTRE; left_ff <= 5'd1; idx_ff <= 5'(hw);
                     end else begin
                        state_ff <= sbr_pkg::ST_IDLE;
                     end
                  end
               end
            end
            sbr_pkg::ST_PLAN: begin
               tap_ff <= '0;
               acc_ff <= '0;
               pv_ff  <= 1'b0;
               unique case (mode_ff)
                  MODE_PASS: begin
                     pos_ff <= idx_ff; zero_ff <= 1'b1;
                     state_ff <= sbr_pkg::ST_ROUND;
                  end
                  MODE_CENTRE: begin
                     set_ff <= 5'(hw); hdir_ff <= 1'b0; zero_ff <= 1'b0;
                     hstart_ff <= 5'(e_ff - 5'({hw, 1'b0}));
                     pos_ff <= 5'(e_ff - 5'(hw));
                     state_ff <= sbr_pkg::ST_READ;
                  end
                  MODE_HEAD: begin
                     set_ff <= idx_ff; hdir_ff <= 1'b0; zero_ff <= 1'b0;
                     hstart_ff <= '0; pos_ff <= idx_ff;
                     state_ff <= sbr_pkg::ST_READ;
                  end
                  MODE_TAIL: begin
                     set_ff <= idx_ff; hdir_ff <= 1'b1; zero_ff <= 1'b0;
                     hstart_ff <= e_ff; pos_ff <= 5'(e_ff - idx_ff);
                     state_ff <= sbr_pkg::ST_READ;
                  end
               endcase
            end
            sbr_pkg::ST_READ: begin
               // RAM read of tap issued; history tap latched alongside
               hs_ff <= hist_ff[h_idx];
               state_ff <= sbr_pkg::ST_MAC;
            end
            sbr_pkg::ST_MAC: begin
               prod_ff <= PB'($signed(coef_rd) * hs_ff);
               pv_ff   <= 1'b1;
               if (pv_ff) acc_ff <= acc_ff + AB'(prod_ff);
               if (tap_ff == taps_ff) begin
                  state_ff <= sbr_pkg::ST_ROUND;
               end else begin
                  tap_ff <= 5'(tap_ff + 5'd1);
                  state_ff <= sbr_pkg::ST_READ;
               end
            end
            sbr_pkg::ST_ROUND: begin
               if (pv_ff) begin
                  acc_ff <= acc_ff + AB'(prod_ff);
                  pv_ff  <= 1'b0;
               end else begin
                  base_ff <= zero_ff ? '0 : sat;
                  plast_ff <= (left_ff == 5'd1) && last_ff;
                  state_ff <= sbr_pkg::ST_OUT;
               end
            end
            sbr_pkg::ST_OUT: begin
               if (rsp_free) begin
                  rbase_ff  <= base_ff;
                  rcorr_ff  <= (SAMPLE_BITS+1)'($signed(hist_ff[pos_ff])) -
                               (SAMPLE_BITS+1)'(base_ff);
                  rlast_ff  <= plast_ff;
                  left_ff   <= 5'(left_ff - 5'd1);
                  if (left_ff == 5'd1) begin
                     state_ff <= sbr_pkg::ST_IDLE;
                  end else begin
                     state_ff <= sbr_pkg::ST_PLAN;
                     if (mode_ff == MODE_PASS || mode_ff == MODE_HEAD)
                        idx_ff <= 5'(idx_ff + 5'd1);
                     else begin
                        mode_ff <= MODE_TAIL;
                        idx_ff  <= (mode_ff == MODE_CENTRE) ? 5'(5'(hw) - 5'd1)
                                                            : 5'(idx_ff - 5'd1);
                     end
                     if (mode_ff == MODE_HEAD && idx_ff == 5'(5'(hw) - 5'd1)) begin
                        mode_ff <= MODE_CENTRE;
                     end
                  end
               end
            end
            default: state_ff <= sbr_pkg::ST_IDLE;
         endcase
      end
   end

   assign rsp.valid       = rvalid_ff;
   assign rsp.corrected   = rcorr_ff;
   assign rsp.baseline    = rbase_ff;
   assign rsp.last_result = rlast_ff;

   `SBR_ASSERT_IMP(a_busy_not_ready, clock, reset,
      state_ff != sbr_pkg::ST_IDLE, !req.ready)
   `SBR_ASSERT_NEXT(a_out_valid, clock, reset,
      state_ff == sbr_pkg::ST_OUT && rsp_free, rvalid_ff)
   `SBR_ASSERT_IMP(a_tap_range, clock, reset,
      state_ff == sbr_pkg::ST_MAC, tap_ff <= taps_ff)
endmodule
`default_nettype wire

FILE: tb/sbr_tb_checker.sv
// Checker: watches the channels, predicts the baseline remover and compares results
`timescale 1ns / 1ps
`default_nettype none
module sbr_tb_checker (
   input wire logic  clock,
   input wire logic  reset,
   sbr_req_if        req,
   sbr_rsp_if        rsp,
   input wire logic  csr_write_enable,
   input wire logic [sbr_pkg::HW_BITS-1:0] csr_write_data,
   output int        fail_count,
   output int        pending_count
);
   typedef struct packed {
      logic signed [16:0] corrected;
      logic signed [15:0] baseline;
      logic               last_result;
   } fit_result_type;

   logic signed [23:0] coef_mem [0:511];
   logic signed [15:0] history [0:31];
   int unsigned        seen;
   int unsigned        hw_reg;
   fit_result_type     expected_q [$];

   assign pending_count = expected_q.size();

   function automatic logic signed [15:0] fit_value(int unsigned set, int unsigned start,
                                                    int unsigned dir, int unsigned window);
      longint acc;
      longint r;
      acc = 0;
      for (int unsigned j = 0; j < window; j++)
         acc += longint'(coef_mem[((set & 15) << 5) | (j & 31)]) *
                longint'(history[(start + dir * j) & 31]);
      r = (acc + (64'sd1 <<< (sbr_pkg::COEF_FRAC_BITS - 1))) >>> sbr_pkg::COEF_FRAC_BITS;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   task automatic push_result(int unsigned pos, logic signed [15:0] base, bit last);
      fit_result_type res;
      logic signed [16:0] x;
      x = history[pos & 31];
      res.corrected = x - base;
      res.baseline = base;
      res.last_result = last;
      expected_q.push_back(res);
   endtask

   task automatic predict_sample(logic signed [15:0] smp, bit last);
      int unsigned hw, window, e, cnt;
      hw = hw_reg > sbr_pkg::MAX_HALF_WIDTH ? sbr_pkg::MAX_HALF_WIDTH : hw_reg;
      e = seen;
      history[e & 31] = smp;
      if (hw == 0) begin
         seen = 0;
         push_result(e, 16'sd0, last);
         return;
      end
      window = 2 * hw + 1;
      cnt = e + 1;
      if (last) begin
         if (cnt <= window) begin
            for (int unsigned i = 0; i < cnt; i++)
               push_result(i, 16'sd0, i + 1 == cnt);
         end else begin
            push_result(e - hw, fit_value(hw, e - 2 * hw, 1, window), 1'b0);
            for (int i = hw - 1; i >= 0; i--)
               push_result(e - i, fit_value(i, e, 31, window), i == 0);
         end
         seen = 0;
         return;
      end
      if (cnt == window) begin
         for (int unsigned i = 0; i <= hw; i++)
            push_result(i, fit_value(i, 0, 1, window), 1'b0);
      end else if (cnt > window) begin
         push_result(e - hw, fit_value(hw, e - 2 * hw, 1, window), 1'b0);
      end
      seen = (cnt < 64) ? cnt : (32 | (cnt & 31));
   endtask

   always @(posedge clock) begin
      fit_result_type exp_res;
      if (reset) begin
         for (int i = 0; i < 32; i++) history[i] = '0;
         seen = 0;
         hw_reg = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (csr_write_enable) hw_reg = csr_write_data;
         if (req.valid && req.ready) begin
            if (req.operation == sbr_pkg::OP_COEF) coef_mem[req.coef_address] = req.coef_value;
            else predict_sample(req.sample, req.last_sample);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected beat corrected=%0d baseline=%0d last=%0b", $time,
                        rsp.corrected, rsp.baseline, rsp.last_result);
               fail_count++;
            end else begin
               exp_res = expected_q.pop_front();
               if (rsp.corrected !== exp_res.corrected) begin
                  $display("%0t: corrected expected %0d actual %0d", $time,
                           exp_res.corrected, rsp.corrected);
                  fail_count++;
               end
               if (rsp.baseline !== exp_res.baseline) begin
                  $display("%0t: baseline expected %0d actual %0d", $time,
                           exp_res.baseline, rsp.baseline);
                  fail_count++;
               end
               if (rsp.last_result !== exp_res.last_result) begin
                  $display("%0t: last_result expected %0b actual %0b", $time,
                           exp_res.last_result, rsp.last_result);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: tb/tb_savgol_baseline_remover.sv
// Testbench top: stimulus, idling and verdict for the baseline remover
`timescale 1ns / 1ps
`default_nettype none
module tb_savgol_baseline_remover;
   localparam int RANDOM_SAMPLES = 24;
   localparam int CYCLE_LIMIT    = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [sbr_pkg::HW_BITS-1:0] csr_write_data = '0;
   int   fail_count, pending_count;
   int   cycle_count = 0;
   bit   rsp_hold = 1'b0;
   bit   quiet = 1'b0;

   sbr_req_if req ();
   sbr_rsp_if rsp ();

   savgol_baseline_remover i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   sbr_tb_checker i_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.operation = sbr_pkg::OP_COEF;
      req.coef_address = '0;
      req.coef_value = '0;
      req.sample = '0;
      req.last_sample = 1'b0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_savgol_baseline_remover failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_hold) rsp.ready <= 1'b0;
      else rsp.ready <= quiet || ($urandom_range(99) >= 8);
   end

   // valid stays high after the beat; the next beat or an idle drops it
   task automatic send_beat(bit op, logic [8:0] addr, logic [23:0] coef,
                            logic [15:0] smp, bit last);
      while (!quiet && $urandom_range(99) < 8) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.operation <= op;
      req.coef_address <= addr;
      req.coef_value <= coef;
      req.sample <= smp;
      req.last_sample <= last;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_half_width(int hw);
      csr_write_enable <= 1'b1;
      csr_write_data <= sbr_pkg::HW_BITS'(hw);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // coefficients for set s, taps 0..2hw, full random, small random or extreme values
   task automatic load_sets(int hw, bit extreme);
      logic [23:0] c;
      for (int s = 0; s <= hw; s++)
         for (int t = 0; t <= 2 * hw; t++) begin
            if (extreme) c = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            else c = $urandom_range(1) ? 24'($urandom)
                                       : 24'(int'($urandom_range(600000)) - 300000);
            send_beat(sbr_pkg::OP_COEF, 9'(s * 32 + t), c, 16'($urandom), 1'b1);
         end
   endtask

   task automatic send_record(int len, int mode);
      logic [15:0] smp;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: smp = 16'($urandom);
            1: smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: smp = 16'(int'($urandom_range(2000)) - 1000);
         endcase
         send_beat(sbr_pkg::OP_SAMPLE, 9'($urandom), 24'($urandom), smp, i == len - 1);
      end
   endtask

   initial begin
      int hw_list [3] = '{3, 0, 2};
      int hw, len, done;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // bypass first, then extremes of coefficients and samples
      send_record(3, 1);
      drain_results();
      set_half_width(2);
      load_sets(2, 1'b1);
      send_record(3, 0);
      send_record(5, 1);
      send_record(9, 1);
      drain_results();
      set_half_width(1);
      load_sets(1, 1'b0);
      // long record: sample count runs past 63 while the output is held off
      rsp_hold = 1'b1;
      fork
         begin
            send_record(66, 0);
            req.valid <= 1'b0;
         end
         begin
            repeat (300) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join
      drain_results();
      done = 0;
      foreach (hw_list[k]) begin
         hw = hw_list[k];
         set_half_width(hw);
         load_sets(hw, 1'b0);
         quiet = (k == 0);
         while (done < RANDOM_SAMPLES * (k + 1) / 3) begin
            len = $urandom_range(1, 14);
            send_record(len, $urandom_range(2));
            done += len;
         end
         drain_results();
      end
      quiet = 1'b0;
      if (fail_count == 0) $display("tb_savgol_baseline_remover passed");
      else $display("tb_savgol_baseline_remover failed");
      $finish;
   end
endmodule
`default_nettype wire
